// ===== rtl/integer_to_radix_ascii_assert.svh =====
// assertion macros for the integer to radix ascii block
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define ITOA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("itoa assertion failed");

// next-cycle implication, sampled on clk, off during rst
`define ITOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("itoa assertion failed");

`endif

// ===== rtl/itoa_pkg.sv =====
// shared constants and helper functions for the integer to radix ascii block
`timescale 1ns / 1ps

package itoa_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RADIX_W = 5;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned DIGIT_W = 4;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  localparam logic OP_SIGNED   = 1'b0;
  localparam logic OP_UNSIGNED = 1'b1;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] b;
    b = r;
    if (r < RADIX_MIN) begin
      b = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      b = RADIX_MAX;
    end
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CHAR_ZERO + CHAR_W'(d);
    end else begin
      c = CHAR_A + CHAR_W'(d - 4'd10);
    end
    return c;
  endfunction

endpackage

// ===== rtl/itoa_in_if.sv =====
// input channel: number, reading mode and base
`timescale 1ns / 1ps

interface itoa_in_if;
  import itoa_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [VALUE_W-1:0] value;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, output opcode, output value, output radix, input ready);
  modport sink   (input valid, input opcode, input value, input radix, output ready);
endinterface

// ===== rtl/itoa_out_if.sv =====
// output channel: one ascii character per item
`timescale 1ns / 1ps

interface itoa_out_if;
  import itoa_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

// ===== rtl/integer_to_radix_ascii.sv =====
// forms d digits (d from 1 to 32), then emits a minus sign if negative and the digits,
// one item per cycle while dout.ready is high; each digit is one division by the base,
// 8 quotient bits per cycle through one shared restoring divide step
// a new number is taken only after the last item of the previous one has been sent
// reset: rst is synchronous and active high, returns the sequencer to idle
`timescale 1ns / 1ps
`include "integer_to_radix_ascii_assert.svh"

module integer_to_radix_ascii (
  input logic clk,
  input logic rst,
  itoa_in_if.sink    din,
  itoa_out_if.source dout
);
  import itoa_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam int unsigned CHUNK_W  = 8;
  localparam int unsigned NCHUNK   = VALUE_W / CHUNK_W;
  localparam int unsigned CHUNKC_W = $clog2(NCHUNK);
  localparam int unsigned IDX_W    = $clog2(VALUE_W);

  logic [1:0]          state;
  logic [VALUE_W-1:0]  work;
  logic [DIGIT_W-1:0]  rem;
  logic [RADIX_W-1:0]  base;
  logic [CHUNKC_W-1:0] chunk;
  logic [IDX_W-1:0]    idx;
  logic                neg;
  logic [DIGIT_W-1:0]  digits [VALUE_W];

  logic [CHUNK_W-1:0]  qbits;
  logic [DIGIT_W-1:0]  r_step;
  logic [RADIX_W-1:0]  t_step;
  logic [VALUE_W-1:0]  work_next;
  logic                last_chunk;

  // shared divide step: 8 quotient bits per cycle, remainder stays below base
  always_comb begin
    r_step = rem;
    t_step = '0;
    qbits  = '0;
    for (int i = 0; i < CHUNK_W; i++) begin
      t_step = {r_step, work[VALUE_W-1-i]};
      if (t_step >= base) begin
        qbits[CHUNK_W-1-i] = 1'b1;
        r_step = DIGIT_W'(t_step - base);
      end else begin
        qbits[CHUNK_W-1-i] = 1'b0;
        r_step = t_step[DIGIT_W-1:0];
      end
    end
    work_next  = {work[VALUE_W-CHUNK_W-1:0], qbits};
    last_chunk = (chunk == CHUNKC_W'(NCHUNK - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      chunk <= '0;
      idx   <= '0;
      neg   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (din.valid) begin
            neg   <= (din.opcode == OP_SIGNED) && din.value[VALUE_W-1];
            chunk <= '0;
            idx   <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          chunk <= chunk + 1'b1;
          if (last_chunk) begin
            if (work_next == '0) begin
              state <= S_EMIT;
            end else begin
              idx <= idx + 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (dout.ready) begin
            if (neg) begin
              neg <= 1'b0;
            end else if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx <= idx - 1'b1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && din.valid) begin
      work <= (din.opcode == OP_SIGNED && din.value[VALUE_W-1]) ? -din.value : din.value;
      base <= clamp_radix(din.radix);
      rem  <= '0;
    end else if (state == S_DIV) begin
      work <= work_next;
      if (last_chunk) begin
        rem         <= '0;
        digits[idx] <= r_step;
      end else begin
        rem <= r_step;
      end
    end
  end

  assign din.ready      = (state == S_IDLE);
  assign dout.valid     = (state == S_EMIT);
  assign dout.char_code = neg ? CHAR_MINUS : digit_char(digits[idx]);
  assign dout.is_last   = !neg && (idx == '0);

  `ITOA_ASSERT_NOW(a_one_side, din.ready, !dout.valid)
  `ITOA_ASSERT_NEXT(a_start_div, din.valid && din.ready, state == S_DIV && chunk == '0)
  `ITOA_ASSERT_NOW(a_rem_below_base, state == S_DIV, {1'b0, rem} < base)
  `ITOA_ASSERT_NEXT(a_last_frees, dout.valid && dout.ready && dout.is_last, din.ready)

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the integer to radix ascii converter
`timescale 1ns / 1ps

module testbench;
  import itoa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1500000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned MAX_GAP      = 13;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
  } char_item_t;

  logic clk;
  logic rst;

  itoa_in_if  in_ch ();
  itoa_out_if out_ch ();

  integer_to_radix_ascii dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  char_item_t  expected_chars[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned sink_gap;
  logic        no_idle;
  logic        hold_out;
  event        hold_start;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic void predict_chars(input logic op, input logic [VALUE_W-1:0] number,
                                        input logic [RADIX_W-1:0] radix);
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] base;
    logic [DIGIT_W-1:0] d;
    logic [CHAR_W-1:0]  digits[$];
    char_item_t         item;
    base = VALUE_W'(radix);
    if (radix < 5'd2) begin
      base = 2;
    end else if (radix > 5'd16) begin
      base = 16;
    end
    mag = number;
    if (op == OP_SIGNED && number[VALUE_W-1]) begin
      item.char_code = CHAR_MINUS;
      item.is_last   = 1'b0;
      expected_chars.push_back(item);
      mag = -number;
    end
    do begin
      d = DIGIT_W'(mag % base);
      if (d < 10) begin
        digits.push_front(CHAR_ZERO + CHAR_W'(d));
      end else begin
        digits.push_front(CHAR_A + CHAR_W'(d - 10));
      end
      mag = mag / base;
    end while (mag != 0);
    foreach (digits[i]) begin
      item.char_code = digits[i];
      item.is_last   = (i == digits.size() - 1);
      expected_chars.push_back(item);
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic offer_number(input logic op, input logic [VALUE_W-1:0] number,
                              input logic [RADIX_W-1:0] radix);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.value  <= number;
    in_ch.radix  <= radix;
    do @(posedge clk); while (!in_ch.ready);
    predict_chars(op, number, radix);
    @(negedge clk);
  endtask

  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 40);
      1: v = 32'hFFFF_FFFF - $urandom_range(0, 40);
      2: v = 32'h8000_0000 + $urandom_range(0, 40) - 20;
      3: v = 32'h1 << $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  function automatic logic [RADIX_W-1:0] draw_radix();
    if ($urandom_range(0, 9) == 0) begin
      return RADIX_W'($urandom_range(0, 31));
    end
    return RADIX_W'($urandom_range(2, 16));
  endfunction

  task automatic test_digit_extremes();
    offer_number(OP_SIGNED, 32'd0, 5'd10);
    offer_number(OP_UNSIGNED, 32'd0, 5'd2);
    offer_number(OP_SIGNED, 32'h8000_0000, 5'd10);
    offer_number(OP_SIGNED, 32'h8000_0000, 5'd2);
    offer_number(OP_SIGNED, 32'h8000_0000, 5'd16);
    offer_number(OP_UNSIGNED, 32'h8000_0000, 5'd10);
    offer_number(OP_SIGNED, 32'h7FFF_FFFF, 5'd10);
    offer_number(OP_SIGNED, 32'hFFFF_FFFF, 5'd10);
    offer_number(OP_UNSIGNED, 32'hFFFF_FFFF, 5'd2);
    offer_number(OP_UNSIGNED, 32'hFFFF_FFFF, 5'd16);
    offer_number(OP_UNSIGNED, 32'hFEDC_BA98, 5'd16);
    offer_number(OP_UNSIGNED, 32'h0123_4567, 5'd16);
    offer_number(OP_UNSIGNED, 32'd123456789, 5'd3);
    offer_number(OP_SIGNED, 32'hFFFF_FF85, 5'd7);
    offer_number(OP_UNSIGNED, 32'd987654321, 5'd13);
  endtask

  task automatic test_radix_saturation();
    offer_number(OP_UNSIGNED, 32'd37, 5'd0);
    offer_number(OP_UNSIGNED, 32'd37, 5'd1);
    offer_number(OP_SIGNED, 32'hFFFF_FFF0, 5'd1);
    offer_number(OP_UNSIGNED, 32'hCAFE_F00D, 5'd17);
    offer_number(OP_SIGNED, 32'hDEAD_BEEF, 5'd31);
    offer_number(OP_UNSIGNED, 32'd255, 5'd15);
  endtask

  task automatic test_random_numbers();
    for (int chunk = 0; chunk < 15; chunk++) begin
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < 30; n++) begin
        offer_number(logic'($urandom_range(0, 1)), draw_value(), draw_radix());
      end
    end
    no_idle = 1'b0;
  endtask

  // receiver stops while items keep coming, so the input must back up
  task automatic test_output_stall();
    no_idle = 1'b1;
    -> hold_start;
    for (int n = 0; n < 12; n++) begin
      offer_number(logic'($urandom_range(0, 1)), draw_value(), draw_radix());
    end
    no_idle = 1'b0;
  endtask

  always begin
    @(hold_start);
    @(posedge clk);
    hold_out <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_out <= 1'b0;
  end

  always @(negedge clk) begin
    out_ch.ready <= (sink_gap == 0) && !hold_out;
  end

  always @(posedge clk) begin
    char_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      sink_gap <= no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (expected_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected item char 0x%02h last %0b",
                                  out_ch.char_code, out_ch.is_last));
      end else begin
        want = expected_chars.pop_front();
        if (out_ch.char_code !== want.char_code) begin
          report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                    out_ch.char_code, want.char_code));
        end
        if (out_ch.is_last !== want.is_last) begin
          report_mismatch($sformatf("is_last %0b, want %0b", out_ch.is_last, want.is_last));
        end
      end
    end else if (sink_gap > 0) begin
      sink_gap <= sink_gap - 1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected",
               cycle_count, expected_chars.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    in_ch.valid  = 1'b0;
    in_ch.opcode = OP_SIGNED;
    in_ch.value  = '0;
    in_ch.radix  = RADIX_MIN;
    out_ch.ready = 1'b0;
    hold_out     = 1'b0;
    no_idle      = 1'b0;
    sink_gap     = 0;
    error_count  = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_digit_extremes();
    test_radix_saturation();
    test_output_stall();
    test_random_numbers();

    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
